// ----- rtl/core/bdbe_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Burley diffuse BRDF evaluator.
// No dependencies; used by bdbe_div and burley_diffuse_brdf_eval.
package bdbe_pkg;

  // Fixed-point constants
  localparam logic [15:0] DIR_ONE    = 16'd16384;
  localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

  // Divider geometry: dividend is dd >> 12, divisor is |s|^2
  localparam int unsigned Q_W        = 16;
  localparam int unsigned REM_W      = 50;
  localparam int unsigned N_W        = 32;
  localparam int unsigned DIV_STAGES = Q_W;

  // Pipeline stage map
  localparam int unsigned DIV_FIRST  = 5;
  localparam int unsigned ST_FD90    = DIV_FIRST + DIV_STAGES;
  localparam int unsigned ST_FRES    = ST_FD90 + 1;
  localparam int unsigned ST_PROD    = ST_FRES + 1;
  localparam int unsigned ST_SCALE   = ST_PROD + 1;
  localparam int unsigned ST_OUT     = ST_SCALE + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_RED   = 2'd0,
    REG_BASE_GREEN = 2'd1,
    REG_BASE_BLUE  = 2'd2,
    REG_ROUGHNESS  = 2'd3
  } reg_idx_e;

  // Sideband that rides along the divider stages
  typedef struct packed {
    logic        blk;
    logic        c2_zero;
    logic        c2_sat;
    logic [16:0] wl;
    logic [16:0] wv;
  } side_t;

  // Saturate a Q1.14 component to [-1, 1]
  function automatic logic signed [15:0] sat_dir(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'sd16384) r = 16'sd16384;
    if (v < -16'sd16384) r = -16'sd16384;
    return r;
  endfunction

  // F = 1 + (fd90 - 1) * w, product scaled down with truncation toward zero
  function automatic logic [18:0] fresnel_q16(input logic [18:0] fd90, input logic [16:0] w);
    logic signed [19:0] diff;
    logic signed [37:0] prod;
    logic signed [37:0] adj;
    logic signed [37:0] q;
    diff = $signed({1'b0, fd90}) - 20'sd65536;
    prod = 38'(diff) * 38'($signed({1'b0, w}));
    adj  = prod[37] ? prod + 38'sd65535 : prod;
    q    = adj >>> 16;
    return 19'(q + 38'sd65536);
  endfunction

endpackage

// ----- rtl/core/bdbe_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for the cos^2 term.
// Depends on bdbe_pkg; stage enables come from the owner's valid chain.
module bdbe_div (
  input  logic                             clk_i,
  input  logic [bdbe_pkg::DIV_STAGES-1:0]  en_i,
  input  logic [bdbe_pkg::REM_W-1:0]       dividend_i,
  input  logic [bdbe_pkg::N_W-1:0]         divisor_i,
  input  bdbe_pkg::side_t                  side_i,
  output logic [bdbe_pkg::Q_W-1:0]         quot_o,
  output bdbe_pkg::side_t                  side_o
);

  logic [bdbe_pkg::REM_W-1:0] rem_q  [bdbe_pkg::DIV_STAGES];
  logic [bdbe_pkg::N_W-1:0]   n_q    [bdbe_pkg::DIV_STAGES];
  logic [bdbe_pkg::Q_W-1:0]   q_q    [bdbe_pkg::DIV_STAGES];
  bdbe_pkg::side_t            side_q [bdbe_pkg::DIV_STAGES];

  for (genvar i = 0; i < bdbe_pkg::DIV_STAGES; i++) begin : g_stg
    localparam int unsigned B = bdbe_pkg::Q_W - 1 - i;
    logic [bdbe_pkg::REM_W-1:0] rem_in, shifted, rem_d;
    logic [bdbe_pkg::N_W-1:0]   n_in;
    logic [bdbe_pkg::Q_W-1:0]   q_in, q_d;
    bdbe_pkg::side_t            s_in;
    logic                       ge;

    if (i == 0) begin : g_first
      assign rem_in = dividend_i;
      assign n_in   = divisor_i;
      assign q_in   = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign n_in   = n_q[i-1];
      assign q_in   = q_q[i-1];
      assign s_in   = side_q[i-1];
    end

    // trial subtract of divisor aligned to this quotient bit
    assign shifted = bdbe_pkg::REM_W'(n_in) << B;
    assign ge      = rem_in >= shifted;
    always_comb begin
      q_d    = q_in;
      q_d[B] = ge;
      rem_d  = ge ? rem_in - shifted : rem_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        rem_q[i]  <= rem_d;
        n_q[i]    <= n_in;
        q_q[i]    <= q_d;
        side_q[i] <= s_in;
      end
    end
  end

  assign quot_o = q_q[bdbe_pkg::DIV_STAGES-1];
  assign side_o = side_q[bdbe_pkg::DIV_STAGES-1];

endmodule

// ----- rtl/core/burley_diffuse_brdf_eval.sv -----
// Burley diffuse BRDF evaluator, top level: input saturation, dot products,
// Schlick weights, cos^2 divider (bdbe_div), Fresnel terms and color scaling.
// Depends on bdbe_pkg and bdbe_div.
//
// One request (incoming and outgoing direction, Q1.14) enters per clock while
// in_ready_o is high, and its RGB result (Q1.15, saturated) passes through 26
// register stages to the output; sustained rate is one request per cycle while
// the output is not stalled. The 16-stage restoring divider forms cos^2 to the
// half vector, one quotient bit per stage. Each stage holds its own
// valid bit and moves whenever the stage after it is empty or moving, so
// bubbles close up and a stalled output only stops the stages behind it once
// they are full. Configuration writes take effect at once and are meant for
// an idle pipeline; roughness and base color are read live.
module burley_diffuse_brdf_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] in_dir_x_i,
  input  logic signed [15:0] in_dir_y_i,
  input  logic signed [15:0] in_dir_z_i,
  input  logic signed [15:0] out_dir_x_i,
  input  logic signed [15:0] out_dir_y_i,
  input  logic signed [15:0] out_dir_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] reflect_red_o,
  output logic [15:0] reflect_green_o,
  output logic [15:0] reflect_blue_o
);

  localparam int unsigned NS = bdbe_pkg::NUM_STAGES;

  // Configuration registers
  logic [15:0] base_r_q, base_g_q, base_b_q, rough_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_r_q <= 16'd32768;
      base_g_q <= 16'd32768;
      base_b_q <= 16'd32768;
      rough_q  <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (bdbe_pkg::reg_idx_e'(cfg_idx_i))
        bdbe_pkg::REG_BASE_RED:   base_r_q <= cfg_wdata_i;
        bdbe_pkg::REG_BASE_GREEN: base_g_q <= cfg_wdata_i;
        bdbe_pkg::REG_BASE_BLUE:  base_b_q <= cfg_wdata_i;
        bdbe_pkg::REG_ROUGHNESS:  rough_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid chain: a stage loads when it is empty or the next one loads
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // Stage 0: saturate components, half-vector sum, back-facing check
  logic signed [15:0] wx_c, wy_c, wz_c, ox_c, oy_c, oz_c;
  logic signed [15:0] wx_q, wy_q, wz_q;
  logic signed [16:0] sx_q, sy_q, sz_q;
  logic [14:0]        ml_q, mv_q;
  logic               blk0_q;

  assign wx_c = bdbe_pkg::sat_dir(in_dir_x_i);
  assign wy_c = bdbe_pkg::sat_dir(in_dir_y_i);
  assign wz_c = bdbe_pkg::sat_dir(in_dir_z_i);
  assign ox_c = bdbe_pkg::sat_dir(out_dir_x_i);
  assign oy_c = bdbe_pkg::sat_dir(out_dir_y_i);
  assign oz_c = bdbe_pkg::sat_dir(out_dir_z_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      wx_q   <= wx_c;
      wy_q   <= wy_c;
      wz_q   <= wz_c;
      sx_q   <= 17'(wx_c) + 17'(ox_c);
      sy_q   <= 17'(wy_c) + 17'(oy_c);
      sz_q   <= 17'(wz_c) + 17'(oz_c);
      ml_q   <= 15'(bdbe_pkg::DIR_ONE - wz_c);
      mv_q   <= 15'(bdbe_pkg::DIR_ONE - oz_c);
      blk0_q <= wz_c[15] || (wz_c == 16'sd0) || oz_c[15] || (oz_c == 16'sd0);
    end
  end

  // Stage 1: dot-product terms, squares, m^2
  logic signed [32:0] pdx_q, pdy_q, pdz_q;
  logic signed [33:0] sqx_c, sqy_c, sqz_c;
  logic [30:0]        sqx_q, sqy_q, sqz_q;
  logic [14:0]        ml1_q, mv1_q, ml2_q, mv2_q;
  logic               blk1_q;

  assign sqx_c = 34'(sx_q) * 34'(sx_q);
  assign sqy_c = 34'(sy_q) * 34'(sy_q);
  assign sqz_c = 34'(sz_q) * 34'(sz_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pdx_q  <= 33'(wx_q) * 33'(sx_q);
      pdy_q  <= 33'(wy_q) * 33'(sy_q);
      pdz_q  <= 33'(wz_q) * 33'(sz_q);
      sqx_q  <= sqx_c[30:0];
      sqy_q  <= sqy_c[30:0];
      sqz_q  <= sqz_c[30:0];
      ml1_q  <= ml_q;
      mv1_q  <= mv_q;
      ml2_q  <= 15'((30'(ml_q) * 30'(ml_q)) >> 14);
      mv2_q  <= 15'((30'(mv_q) * 30'(mv_q)) >> 14);
      blk1_q <= blk0_q;
    end
  end

  // Stage 2: d = wi.s, n = |s|^2, m^4
  logic signed [31:0] d_q;
  logic [31:0]        n2_q;
  logic [14:0]        ml2b_q, mv2b_q, ml4_q, mv4_q;
  logic               blk2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      d_q    <= 32'(pdx_q) + 32'(pdy_q) + 32'(pdz_q);
      n2_q   <= 32'(sqx_q) + 32'(sqy_q) + 32'(sqz_q);
      ml2b_q <= ml1_q;
      mv2b_q <= mv1_q;
      ml4_q  <= 15'((30'(ml2_q) * 30'(ml2_q)) >> 14);
      mv4_q  <= 15'((30'(mv2_q) * 30'(mv2_q)) >> 14);
      blk2_q <= blk1_q;
    end
  end

  // Stage 3: d^2 and Schlick weights
  logic [61:0] dd_q;
  logic [31:0] n3_q;
  logic [16:0] wl_q, wv_q;
  logic        dz_q, blk3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dd_q   <= 62'(d_q[30:0]) * 62'(d_q[30:0]);
      dz_q   <= d_q[31] || (d_q == 32'sd0);
      n3_q   <= n2_q;
      wl_q   <= 17'((30'(ml4_q) * 30'(ml2b_q)) >> 12);
      wv_q   <= 17'((30'(mv4_q) * 30'(mv2b_q)) >> 12);
      blk3_q <= blk2_q;
    end
  end

  // Stage 4: saturation test for cos^2 and divider operands
  logic [bdbe_pkg::REM_W-1:0] x_q;
  logic [bdbe_pkg::N_W-1:0]   n4_q;
  bdbe_pkg::side_t            side4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x_q             <= dd_q[61:12];
      n4_q            <= n3_q;
      side4_q.blk     <= blk3_q;
      side4_q.c2_zero <= dz_q;
      side4_q.c2_sat  <= dd_q >= {2'b00, n3_q, 28'd0};
      side4_q.wl      <= wl_q;
      side4_q.wv      <= wv_q;
    end
  end

  // Stages 5..20: quotient of d^2 / (n * 2^12)
  logic [bdbe_pkg::Q_W-1:0] quot;
  bdbe_pkg::side_t          side_div;

  bdbe_div u_div (
    .clk_i      (clk_i),
    .en_i       (en[bdbe_pkg::DIV_FIRST +: bdbe_pkg::DIV_STAGES]),
    .dividend_i (x_q),
    .divisor_i  (n4_q),
    .side_i     (side4_q),
    .quot_o     (quot),
    .side_o     (side_div)
  );

  // FD90 = 0.5 + 2 * roughness * cos^2
  logic [16:0] c2_c;
  logic [18:0] fd90_q;
  logic [16:0] wl5_q, wv5_q;
  logic        blk5_q;

  always_comb begin
    if (side_div.c2_zero) begin
      c2_c = '0;
    end else if (side_div.c2_sat) begin
      c2_c = 17'd65536;
    end else begin
      c2_c = {1'b0, quot};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[bdbe_pkg::ST_FD90]) begin
      fd90_q <= 19'((33'(rough_q) * 33'(c2_c)) >> 14) + 19'd32768;
      wl5_q  <= side_div.wl;
      wv5_q  <= side_div.wv;
      blk5_q <= side_div.blk;
    end
  end

  // Fresnel terms for light and view
  logic [18:0] fl_q, fv_q;
  logic        blk6_q;

  always_ff @(posedge clk_i) begin
    if (en[bdbe_pkg::ST_FRES]) begin
      fl_q   <= bdbe_pkg::fresnel_q16(fd90_q, wl5_q);
      fv_q   <= bdbe_pkg::fresnel_q16(fd90_q, wv5_q);
      blk6_q <= blk5_q;
    end
  end

  // FL * FV
  logic [21:0] p_q;
  logic        blk7_q;

  always_ff @(posedge clk_i) begin
    if (en[bdbe_pkg::ST_PROD]) begin
      p_q    <= 22'((38'(fl_q) * 38'(fv_q)) >> 16);
      blk7_q <= blk6_q;
    end
  end

  // Divide by pi via reciprocal
  logic [20:0] s_q;
  logic        blk8_q;

  always_ff @(posedge clk_i) begin
    if (en[bdbe_pkg::ST_SCALE]) begin
      s_q    <= 21'((51'(p_q) * 51'(bdbe_pkg::INV_PI_Q30)) >> 30);
      blk8_q <= blk7_q;
    end
  end

  // Output register: scale base color and saturate; back-facing requests give zero
  logic [20:0] r_c, g_c, b_c;
  logic [15:0] red_q, green_q, blue_q;

  assign r_c = 21'((37'(base_r_q) * 37'(s_q)) >> 16);
  assign g_c = 21'((37'(base_g_q) * 37'(s_q)) >> 16);
  assign b_c = 21'((37'(base_b_q) * 37'(s_q)) >> 16);

  always_ff @(posedge clk_i) begin
    if (en[bdbe_pkg::ST_OUT]) begin
      if (blk8_q) begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end else begin
        red_q   <= (r_c > 21'd65535) ? 16'hFFFF : r_c[15:0];
        green_q <= (g_c > 21'd65535) ? 16'hFFFF : g_c[15:0];
        blue_q  <= (b_c > 21'd65535) ? 16'hFFFF : b_c[15:0];
      end
    end
  end

  assign reflect_red_o   = red_q;
  assign reflect_green_o = green_q;
  assign reflect_blue_o  = blue_q;

  // Input backpressure only when every stage holds a request
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // Fresnel terms of a front-facing request never fall below one half
  a_fres_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[bdbe_pkg::ST_FRES] && !blk6_q) |-> (fl_q >= 19'd32768) && (fv_q >= 19'd32768))
    else $error("Fresnel term below one half");

  // A held result keeps its valid, red and blue outputs while the consumer stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(red_q) && $stable(blue_q))
    else $error("output changed under stall");

endmodule
